[src/ulfp_pkg.sv]
// Package for the UART LED frame parser: word types, state codes, event codes
// and header constants. It depends on nothing else.
package ulfp_pkg;

  // Frame headers as seen in the 16-bit shift of recent bytes.
  localparam logic [15:0] HDR_LED     = 16'hAA55;
  localparam logic [15:0] HDR_TRIGGER = 16'h55AA;
  localparam logic [15:0] HDR_CMD     = 16'h3030;

  // Line terminators that end a text command.
  localparam logic [7:0] CH_CR = 8'h0D;
  localparam logic [7:0] CH_LF = 8'h0A;

  // Held parser states. The header states pass through within one byte.
  typedef enum logic [4:0] {
    ST_IDLE   = 5'b00001,
    ST_CMD    = 5'b00010,
    ST_SIZE_1 = 5'b00100,
    ST_SIZE_2 = 5'b01000,
    ST_DATA   = 5'b10000
  } state_t;

  // Event codes reported with each result word.
  typedef enum logic [2:0] {
    EV_NONE       = 3'd0,
    EV_LED_HEADER = 3'd1,
    EV_SIZE_FIRST = 3'd2,
    EV_DATA_BEGIN = 3'd3,
    EV_DATA_DONE  = 3'd4,
    EV_TRIGGER    = 3'd5,
    EV_ERROR      = 3'd6
  } event_t;

  // One received word.
  typedef struct packed {
    logic [7:0] rx_byte;
    logic       frame_error;
  } in_word_t;

  // One result word.
  typedef struct packed {
    event_t     event_res;
    logic       led_push;
    logic       cmd_push;
    logic       cmd_end;
    logic       trigger;
    logic [7:0] out_byte;
  } out_word_t;

  // Parser state carried from one word to the next.
  typedef struct packed {
    state_t      frame_state;
    logic [15:0] shift_word;
    logic [15:0] bytes_left;
  } parse_state_t;

endpackage

[src/ulfp_in_if.sv]
// Input channel of the UART LED frame parser: handshake and received word.
// Depends on nothing else.
interface ulfp_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;
  logic       frame_error;

  modport source (output valid, output rx_byte, output frame_error, input ready);
  modport sink (input valid, input rx_byte, input frame_error, output ready);
endinterface

[src/ulfp_out_if.sv]
// Output channel of the UART LED frame parser: handshake and result word.
// Depends on nothing else.
interface ulfp_out_if;
  logic       valid;
  logic       ready;
  logic [2:0] event_res;
  logic       led_push;
  logic       cmd_push;
  logic       cmd_end;
  logic       trigger;
  logic [7:0] out_byte;

  modport source (
    output valid, output event_res, output led_push, output cmd_push,
    output cmd_end, output trigger, output out_byte, input ready
  );
  modport sink (
    input valid, input event_res, input led_push, input cmd_push,
    input cmd_end, input trigger, input out_byte, output ready
  );
endinterface

[src/ulfp_step.sv]
// Next-state and result logic of the frame parser for one received word.
// Depends on ulfp_pkg.
module ulfp_step
  import ulfp_pkg::*;
(
  input  parse_state_t cur,
  input  in_word_t     word,
  output parse_state_t nxt,
  output out_word_t    res
);

  logic [15:0] shifted;
  logic [15:0] left_dec;

  assign shifted  = {cur.shift_word[7:0], word.rx_byte};
  assign left_dec = cur.bytes_left - 16'd1;

  // One parser step; header matches in idle are handled in the same step.
  always_comb begin
    nxt = cur;
    res = '0;
    res.event_res = EV_NONE;
    if (word.frame_error) begin
      nxt.frame_state = ST_IDLE;
      nxt.shift_word  = '0;
      res.event_res   = EV_ERROR;
    end else begin
      nxt.shift_word = shifted;
      case (cur.frame_state)
        ST_IDLE: begin
          if (shifted == HDR_LED) begin
            res.event_res   = EV_LED_HEADER;
            nxt.shift_word  = '0;
            nxt.frame_state = ST_SIZE_1;
          end else if (shifted == HDR_CMD) begin
            nxt.frame_state = ST_CMD;
          end else if (shifted == HDR_TRIGGER) begin
            res.event_res   = EV_TRIGGER;
            res.trigger     = 1'b1;
            nxt.shift_word  = '0;
            nxt.frame_state = ST_IDLE;
          end else begin
            nxt.frame_state = ST_IDLE;
          end
        end
        ST_SIZE_1: begin
          res.event_res   = EV_SIZE_FIRST;
          nxt.frame_state = ST_SIZE_2;
        end
        ST_SIZE_2: begin
          res.event_res   = EV_DATA_BEGIN;
          nxt.bytes_left  = shifted;
          nxt.shift_word  = '0;
          nxt.frame_state = ST_DATA;
        end
        ST_DATA: begin
          // A length of zero wraps here, giving a full 65536-byte frame.
          res.led_push   = 1'b1;
          res.out_byte   = word.rx_byte;
          nxt.bytes_left = left_dec;
          if (left_dec == 16'd0) begin
            res.event_res   = EV_DATA_DONE;
            nxt.shift_word  = '0;
            nxt.frame_state = ST_IDLE;
          end
        end
        ST_CMD: begin
          res.cmd_push = 1'b1;
          res.out_byte = word.rx_byte;
          if (word.rx_byte inside {CH_CR, CH_LF}) begin
            res.cmd_end     = 1'b1;
            nxt.shift_word  = '0;
            nxt.frame_state = ST_IDLE;
          end
        end
        default: begin
          nxt.frame_state = ST_IDLE;
        end
      endcase
    end
  end

endmodule

[src/uart_led_frame_parser_core.sv]
// Top level of the UART LED frame parser: input register, parser step and
// result register. Depends on ulfp_pkg, ulfp_in_if, ulfp_out_if and ulfp_step.
//
//   Channel  Dir  Word fields
//   in_ch    in   rx_byte[7:0], frame_error
//   out_ch   out  event_res[2:0], led_push, cmd_push, cmd_end, trigger, out_byte[7:0]
//
// Every received word gives exactly one result word; it passes from the input register
// to the result register, and one word is taken per cycle unless the output stalls.
// The input register and the result register each hold one word, so a new word
// is accepted into a free input register while a finished result waits on the output.
// Synchronous reset puts the parser in idle with a cleared shift and count.
module uart_led_frame_parser_core
  import ulfp_pkg::*;
(
  input logic      clk,
  input logic      rst,
  ulfp_in_if.sink  in_ch,
  ulfp_out_if.source out_ch
);

  logic         in_valid;
  in_word_t     in_word;
  logic         out_valid;
  out_word_t    out_word;
  parse_state_t pstate;
  parse_state_t pstate_next;
  out_word_t    res_next;
  logic         advance;

  // A word moves into the result register when that register is free or drains.
  assign advance     = in_valid && (!out_valid || out_ch.ready);
  assign in_ch.ready = !in_valid || advance;

  // Input register.
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (in_ch.ready) begin
      in_valid <= in_ch.valid;
    end
    if (in_ch.ready && in_ch.valid) begin
      in_word.rx_byte     <= in_ch.rx_byte;
      in_word.frame_error <= in_ch.frame_error;
    end
  end

  ulfp_step u_step (
    .cur  (pstate),
    .word (in_word),
    .nxt  (pstate_next),
    .res  (res_next)
  );

  // Parser state advances with each word handed to the result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      pstate.frame_state <= ST_IDLE;
      pstate.shift_word  <= '0;
      pstate.bytes_left  <= '0;
    end else if (advance) begin
      pstate <= pstate_next;
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid <= 1'b0;
    end
    if (advance) begin
      out_word <= res_next;
    end
  end

  assign out_ch.valid     = out_valid;
  assign out_ch.event_res = out_word.event_res;
  assign out_ch.led_push  = out_word.led_push;
  assign out_ch.cmd_push  = out_word.cmd_push;
  assign out_ch.cmd_end   = out_word.cmd_end;
  assign out_ch.trigger   = out_word.trigger;
  assign out_ch.out_byte  = out_word.out_byte;

  // LED data and command text are never handed out together.
  a_push_exclusive: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !(out_word.led_push && out_word.cmd_push))
    else $error("led_push and cmd_push both set");

  // The trigger flag comes only with the trigger event.
  a_trigger_event: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_word.trigger) |-> (out_word.event_res == EV_TRIGGER))
    else $error("trigger without trigger event");

  // A command end is always on a command byte.
  a_cmd_end_push: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_word.cmd_end) |-> out_word.cmd_push)
    else $error("cmd_end without cmd_push");

  // No byte is shown unless it is pushed somewhere.
  a_byte_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_word.led_push && !out_word.cmd_push) |->
      (out_word.out_byte == 8'd0))
    else $error("out_byte set without a push");

  // A framing error leaves the parser idle with a cleared shift.
  a_error_idle: assert property (@(posedge clk) disable iff (rst)
    (advance && in_word.frame_error) |=>
      (pstate.frame_state == ST_IDLE && pstate.shift_word == 16'd0))
    else $error("framing error did not return to idle");

endmodule

[verif/tb_uart_led_frame_parser_core.sv]
// Testbench for the UART LED frame parser core: directed and random byte streams
// checked word by word against a parser model kept in this file.
// Depends on ulfp_pkg, ulfp_in_if, ulfp_out_if and uart_led_frame_parser_core.
module tb_uart_led_frame_parser_core;
  import ulfp_pkg::*;

  localparam int unsigned CYCLE_LIMIT   = 1_000_000;
  localparam int unsigned IDLE_PCT      = 27;
  localparam int unsigned QUIET_FROM    = 1_000;
  localparam int unsigned QUIET_TO      = 1_300;
  localparam int unsigned HOLD_FROM     = 400;
  localparam int unsigned HOLD_CYCLES   = 400;
  localparam int unsigned DRAIN_WAIT    = 10;
  localparam int unsigned RANDOM_HALF   = 580;
  localparam int unsigned ZERO_LEN_DATA = 40;

  // One stimulus row: the received word and, where typed in, its result word.
  typedef struct packed {
    logic [7:0] b;
    logic       ferr;
    logic       fixed;
    out_word_t  want;
  } feed_row_t;

  localparam out_word_t NO_CHECK   = '0;
  localparam out_word_t W_NONE     = '{EV_NONE, 1'b0, 1'b0, 1'b0, 1'b0, 8'h00};
  localparam out_word_t W_ERROR    = '{EV_ERROR, 1'b0, 1'b0, 1'b0, 1'b0, 8'h00};
  localparam out_word_t W_TRIGGER  = '{EV_TRIGGER, 1'b0, 1'b0, 1'b0, 1'b1, 8'h00};
  localparam out_word_t W_LED_HDR  = '{EV_LED_HEADER, 1'b0, 1'b0, 1'b0, 1'b0, 8'h00};
  localparam out_word_t W_SIZE_1ST = '{EV_SIZE_FIRST, 1'b0, 1'b0, 1'b0, 1'b0, 8'h00};

  // Directed stream: extremes, every header, both terminators, errors mid-frame.
  localparam int unsigned N_DIRECTED = 25;
  localparam feed_row_t DIRECTED_ROWS [N_DIRECTED] = '{
    '{8'h00, 1'b0, 1'b1, W_NONE},
    '{8'hFF, 1'b1, 1'b1, W_ERROR},
    '{8'hFF, 1'b0, 1'b0, NO_CHECK},
    '{HDR_TRIGGER[15:8], 1'b0, 1'b0, NO_CHECK},
    '{HDR_TRIGGER[7:0], 1'b0, 1'b1, W_TRIGGER},
    '{HDR_CMD[15:8], 1'b0, 1'b0, NO_CHECK},
    '{HDR_CMD[7:0], 1'b0, 1'b0, NO_CHECK},
    '{8'hFF, 1'b0, 1'b0, NO_CHECK},
    '{8'h00, 1'b0, 1'b0, NO_CHECK},
    '{CH_CR, 1'b0, 1'b0, NO_CHECK},
    '{HDR_CMD[15:8], 1'b0, 1'b0, NO_CHECK},
    '{HDR_CMD[7:0], 1'b0, 1'b0, NO_CHECK},
    '{8'h41, 1'b0, 1'b0, NO_CHECK},
    '{CH_LF, 1'b0, 1'b0, NO_CHECK},
    '{HDR_LED[15:8], 1'b0, 1'b0, NO_CHECK},
    '{HDR_LED[7:0], 1'b0, 1'b1, W_LED_HDR},
    '{8'h00, 1'b0, 1'b1, W_SIZE_1ST},
    '{8'h02, 1'b0, 1'b0, NO_CHECK},
    '{8'hFF, 1'b0, 1'b0, NO_CHECK},
    '{8'h00, 1'b0, 1'b0, NO_CHECK},
    '{HDR_LED[15:8], 1'b0, 1'b0, NO_CHECK},
    '{HDR_LED[7:0], 1'b0, 1'b1, W_LED_HDR},
    '{8'h01, 1'b0, 1'b1, W_SIZE_1ST},
    '{8'h5A, 1'b1, 1'b1, W_ERROR},
    '{8'h00, 1'b0, 1'b0, NO_CHECK}
  };

  logic clk;
  logic rst;
  int unsigned cyc;
  int unsigned mismatches;
  logic quiet;

  feed_row_t    byte_feed_q[$];
  out_word_t    result_due_q[$];
  feed_row_t    on_offer;
  out_word_t    parsed;
  parse_state_t parser_st;

  ulfp_in_if  in_ch ();
  ulfp_out_if out_ch ();

  uart_led_frame_parser_core uut (
    .clk    (clk),
    .rst    (rst),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  // Clock and cycle count; the count also bounds the run.
  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  always @(posedge clk) begin
    cyc <= cyc + 1;
    if (cyc >= CYCLE_LIMIT) begin
      $display("tb_uart_led_frame_parser_core failed");
      $finish;
    end
  end

  assign quiet = (cyc >= QUIET_FROM) && (cyc < QUIET_TO);

  // Parser model: advances parser_st by one received word and returns its result.
  function automatic out_word_t parse_byte(input logic [7:0] b, input logic ferr);
    out_word_t r;
    r = W_NONE;
    if (ferr) begin
      parser_st.frame_state = ST_IDLE;
      parser_st.shift_word = '0;
      r.event_res = EV_ERROR;
    end else begin
      parser_st.shift_word = {parser_st.shift_word[7:0], b};
      case (parser_st.frame_state)
        ST_IDLE: begin
          // Headers are only looked for while idle and act in the same word.
          if (parser_st.shift_word == HDR_LED) begin
            r.event_res = EV_LED_HEADER;
            parser_st.shift_word = '0;
            parser_st.frame_state = ST_SIZE_1;
          end else if (parser_st.shift_word == HDR_TRIGGER) begin
            r.event_res = EV_TRIGGER;
            r.trigger = 1'b1;
            parser_st.shift_word = '0;
          end else if (parser_st.shift_word == HDR_CMD) begin
            parser_st.frame_state = ST_CMD;
          end
        end
        ST_SIZE_1: begin
          r.event_res = EV_SIZE_FIRST;
          parser_st.frame_state = ST_SIZE_2;
        end
        ST_SIZE_2: begin
          parser_st.bytes_left = parser_st.shift_word;
          r.event_res = EV_DATA_BEGIN;
          parser_st.shift_word = '0;
          parser_st.frame_state = ST_DATA;
        end
        ST_DATA: begin
          // A length of zero wraps here, so 65536 data bytes follow.
          r.led_push = 1'b1;
          r.out_byte = b;
          parser_st.bytes_left = parser_st.bytes_left - 16'd1;
          if (parser_st.bytes_left == 16'd0) begin
            r.event_res = EV_DATA_DONE;
            parser_st.shift_word = '0;
            parser_st.frame_state = ST_IDLE;
          end
        end
        ST_CMD: begin
          r.cmd_push = 1'b1;
          r.out_byte = b;
          if (b == CH_CR || b == CH_LF) begin
            r.cmd_end = 1'b1;
            parser_st.shift_word = '0;
            parser_st.frame_state = ST_IDLE;
          end
        end
        default: begin
          parser_st.frame_state = ST_IDLE;
        end
      endcase
    end
    return r;
  endfunction

  task automatic push_word(input logic [7:0] b, input logic ferr);
    feed_row_t r;
    r = '0;
    r.b = b;
    r.ferr = ferr;
    byte_feed_q.push_back(r);
  endtask

  // LED frame with a given length field; a zero field carries 65536 data bytes.
  // A broken frame takes a framing error at a random size or data position.
  task automatic add_led_frame(input logic [15:0] len_field, input bit broken);
    int unsigned n_data;
    int unsigned cut;
    logic [7:0] b;
    n_data = (len_field == 16'd0) ? 65536 : len_field;
    cut = broken ? $urandom_range(n_data + 1) : n_data + 2;
    push_word(HDR_LED[15:8], 1'b0);
    push_word(HDR_LED[7:0], 1'b0);
    for (int unsigned j = 0; j < n_data + 2; j++) begin
      if (j == 0) b = len_field[15:8];
      else if (j == 1) b = len_field[7:0];
      else b = 8'($urandom);
      if (j == cut) begin
        push_word(b, 1'b1);
        return;
      end
      push_word(b, 1'b0);
    end
  endtask

  // Text command with random text, closed by CR or LF unless broken.
  task automatic add_command(input bit broken);
    int unsigned n_text;
    logic [7:0] b;
    n_text = $urandom_range(10);
    push_word(HDR_CMD[15:8], 1'b0);
    push_word(HDR_CMD[7:0], 1'b0);
    for (int unsigned j = 0; j < n_text; j++) begin
      b = 8'($urandom);
      while (b == CH_CR || b == CH_LF) b = 8'($urandom);
      push_word(b, 1'b0);
    end
    if (broken) push_word(8'($urandom), 1'b1);
    else push_word(($urandom_range(1) != 0) ? CH_CR : CH_LF, 1'b0);
  endtask

  // Mostly well-formed frames with random content, plus noise and broken frames.
  task automatic add_random_part(input int unsigned target);
    int unsigned added;
    int unsigned pick;
    int unsigned mark;
    logic [15:0] len;
    added = 0;
    while (added < target) begin
      mark = byte_feed_q.size();
      pick = $urandom_range(99);
      if (pick < 40) begin
        len = ($urandom_range(49) == 0) ? 16'($urandom_range(600, 256))
                                        : 16'($urandom_range(16, 1));
        add_led_frame(len, $urandom_range(9) == 0);
      end else if (pick < 55) begin
        push_word(HDR_TRIGGER[15:8], 1'b0);
        push_word(HDR_TRIGGER[7:0], 1'b0);
      end else if (pick < 80) begin
        add_command($urandom_range(9) == 0);
      end else begin
        repeat ($urandom_range(4, 1)) push_word(8'($urandom), $urandom_range(19) == 0);
      end
      if (pick < 80) added += byte_feed_q.size() - mark;
    end
  endtask

  // Input side: offer words with random gaps; model each word as it is taken.
  always @(posedge clk) begin
    if (rst) begin
      in_ch.valid <= 1'b0;
    end else begin
      if (in_ch.valid && in_ch.ready) begin
        parsed = parse_byte(on_offer.b, on_offer.ferr);
        result_due_q.push_back(on_offer.fixed ? on_offer.want : parsed);
      end
      if (!in_ch.valid || in_ch.ready) begin
        if (byte_feed_q.size() != 0 && (quiet || $urandom_range(99) >= IDLE_PCT)) begin
          on_offer = byte_feed_q.pop_front();
          in_ch.valid <= 1'b1;
          in_ch.rx_byte <= on_offer.b;
          in_ch.frame_error <= on_offer.ferr;
        end else begin
          in_ch.valid <= 1'b0;
        end
      end
    end
  end

  // Output side: random stalls, and one long hold-off so the core backs up.
  always @(posedge clk) begin : sink_side
    int unsigned sink_cycles;
    if (rst) begin
      out_ch.ready <= 1'b0;
      sink_cycles = 0;
    end else begin
      sink_cycles++;
      if (sink_cycles >= HOLD_FROM && sink_cycles < HOLD_FROM + HOLD_CYCLES)
        out_ch.ready <= 1'b0;
      else
        out_ch.ready <= quiet || ($urandom_range(99) >= IDLE_PCT);
    end
  end

  task automatic check_field(input string name, input logic [7:0] want_v,
                             input logic [7:0] got_v);
    if (got_v !== want_v) begin
      $error("%s: expected %0h, got %0h", name, want_v, got_v);
      mismatches++;
    end
  endtask

  // Compare every taken result word with the oldest one due.
  always @(posedge clk) begin : check_results
    out_word_t want;
    if (!rst && out_ch.valid && out_ch.ready) begin
      if (result_due_q.size() == 0) begin
        $error("result word with none due: event_res %0h out_byte %0h",
               out_ch.event_res, out_ch.out_byte);
        mismatches++;
      end else begin
        want = result_due_q.pop_front();
        check_field("event_res", 8'(want.event_res), 8'(out_ch.event_res));
        check_field("led_push", 8'(want.led_push), 8'(out_ch.led_push));
        check_field("cmd_push", 8'(want.cmd_push), 8'(out_ch.cmd_push));
        check_field("cmd_end", 8'(want.cmd_end), 8'(out_ch.cmd_end));
        check_field("trigger", 8'(want.trigger), 8'(out_ch.trigger));
        check_field("out_byte", want.out_byte, out_ch.out_byte);
      end
    end
  end

  // Build the stream, run reset, then wait for the last result.
  initial begin
    clk = 1'b0;
    rst = 1'b1;
    cyc = 0;
    mismatches = 0;
    parser_st = '{ST_IDLE, 16'h0000, 16'h0000};
    in_ch.valid = 1'b0;
    in_ch.rx_byte = 8'h00;
    in_ch.frame_error = 1'b0;
    out_ch.ready = 1'b0;

    for (int unsigned i = 0; i < N_DIRECTED; i++) byte_feed_q.push_back(DIRECTED_ROWS[i]);
    add_random_part(RANDOM_HALF);
    // A framing error forces idle before a zero-length frame. Its count wraps,
    // so the data runs on past the first byte until a framing error cuts it.
    push_word(8'h00, 1'b1);
    push_word(HDR_LED[15:8], 1'b0);
    push_word(HDR_LED[7:0], 1'b0);
    push_word(8'h00, 1'b0);
    push_word(8'h00, 1'b0);
    for (int unsigned i = 0; i < ZERO_LEN_DATA; i++) push_word(8'($urandom), 1'b0);
    push_word(8'($urandom), 1'b1);
    add_random_part(RANDOM_HALF);

    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // Sample between edges, once every register and queue has settled.
    @(negedge clk);
    while (byte_feed_q.size() != 0 || in_ch.valid || result_due_q.size() != 0)
      @(negedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);

    if (mismatches == 0) begin
      $display("tb_uart_led_frame_parser_core passed");
    end else begin
      $display("tb_uart_led_frame_parser_core failed");
    end
    $finish;
  end

endmodule

[files.f]
src/ulfp_pkg.sv
src/ulfp_in_if.sv
src/ulfp_out_if.sv
src/ulfp_step.sv
src/uart_led_frame_parser_core.sv
verif/tb_uart_led_frame_parser_core.sv
